// ===== rtl/rgc_pkg.sv =====
// rgc_pkg: shared types and constants of the rgb565 gradient color unit
// depends on nothing; used by rgc_blend and rgb565_gradient_color_unit
package rgc_pkg;

  localparam int LINES   = 128;
  localparam int LINE_W  = $clog2(LINES);
  localparam int DUR_W   = 16;
  localparam int COLOR_W = 16;
  localparam int IN_LINE_W = 10;

  // line * duration and its exact division by LINES - 1
  localparam int MIX_D   = LINES - 1;
  localparam int MIX_K   = LINE_W + DUR_W;
  localparam int MIX_M_W = MIX_K + 1;
  localparam logic [MIX_M_W-1:0] MIX_M = MIX_M_W'((64'd1 << MIX_K) / MIX_D);

  // blend pipeline: products, sum, three stages of two quotient bits
  localparam int BLEND_LAT = 5;
  localparam int LANE_W    = 6;
  localparam int NUM_W     = LANE_W + DUR_W;

  localparam logic [DUR_W-1:0]   DURATION_RST = 16'd4000;
  localparam logic [COLOR_W-1:0] TOP_RST      = 16'h39E7;
  localparam logic [COLOR_W-1:0] BOTTOM_RST   = 16'h0842;
  localparam logic [COLOR_W-1:0] START_RST    = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_TOP      = 2'd1,
    REG_BOTTOM   = 2'd2,
    REG_START    = 2'd3
  } rgc_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] from_color;
    logic [COLOR_W-1:0] to_color;
    logic [DUR_W-1:0]   step;
  } rgc_blend_req_t;

endpackage

// ===== rtl/rgc_blend.sv =====
// rgc_blend: pipelined rgb565 blend, per-channel multiply, sum and restoring divide
// depends on rgc_pkg; step must already be clamped to den
module rgc_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  rgc_pkg::rgc_blend_req_t      in_req,
  input  logic [rgc_pkg::DUR_W-1:0]    den,
  output logic                         out_valid,
  output logic [rgc_pkg::COLOR_W-1:0]  out_color
);

  localparam int NW  = rgc_pkg::NUM_W;
  localparam int LW  = rgc_pkg::LANE_W;
  localparam int LAT = rgc_pkg::BLEND_LAT;

  logic [LAT-1:0] v_r;

  logic [LW-1:0]   lane_from [0:2];
  logic [LW-1:0]   lane_to   [0:2];
  logic [rgc_pkg::DUR_W-1:0] dmin;

  logic [NW-1:0] pf_r  [0:2];
  logic [NW-1:0] pt_r  [0:2];
  logic [NW-1:0] num_r [0:2];

  logic [NW-1:0] rem_src [0:2][0:2];
  logic [LW-1:0] quo_src [0:2][0:2];
  logic [NW-1:0] rem_nxt [0:2][0:2];
  logic [LW-1:0] quo_nxt [0:2][0:2];
  logic [NW-1:0] rem_r   [0:2][0:2];
  logic [LW-1:0] quo_r   [0:2][0:2];

  always_comb begin
    lane_from[0] = {1'b0, in_req.from_color[15:11]};
    lane_from[1] = in_req.from_color[10:5];
    lane_from[2] = {1'b0, in_req.from_color[4:0]};
    lane_to[0]   = {1'b0, in_req.to_color[15:11]};
    lane_to[1]   = in_req.to_color[10:5];
    lane_to[2]   = {1'b0, in_req.to_color[4:0]};
    dmin         = den - in_req.step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // products and sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        pf_r[l]  <= NW'(lane_from[l]) * NW'(dmin);
        pt_r[l]  <= NW'(lane_to[l]) * NW'(in_req.step);
        num_r[l] <= pf_r[l] + pt_r[l];
      end
    end
  end

  // two quotient bits per stage, quotient always below 64
  for (genvar gs = 0; gs < 3; gs++) begin : g_div
    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      if (gs == 0) begin : g_first
        assign rem_src[gs][gl] = num_r[gl];
        assign quo_src[gs][gl] = '0;
      end else begin : g_next
        assign rem_src[gs][gl] = rem_r[gs-1][gl];
        assign quo_src[gs][gl] = quo_r[gs-1][gl];
      end

      always_comb begin
        logic [NW-1:0] rem_v;
        logic [NW-1:0] sub_v;
        logic [LW-1:0] q_v;
        rem_v = rem_src[gs][gl];
        q_v   = quo_src[gs][gl];
        for (int b = 0; b < 2; b++) begin
          sub_v = NW'(den) << (LW - 1 - 2 * gs - b);
          if (rem_v >= sub_v) begin
            rem_v = rem_v - sub_v;
            q_v[LW - 1 - 2 * gs - b] = 1'b1;
          end
        end
        rem_nxt[gs][gl] = rem_v;
        quo_nxt[gs][gl] = q_v;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[gs][gl] <= rem_nxt[gs][gl];
          quo_r[gs][gl] <= quo_nxt[gs][gl];
        end
      end
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_color = {quo_r[2][0][4:0], quo_r[2][1][5:0], quo_r[2][2][4:0]};

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAT-1] && den != '0) |-> (rem_r[2][0] < NW'(den) && rem_r[2][1] < NW'(den)
      && rem_r[2][2] < NW'(den)))
    else $error("blend remainder not below divisor");

  a_five_bit_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAT-1] && den != '0) |-> (!quo_r[2][0][LW-1] && !quo_r[2][2][LW-1]))
    else $error("red or blue quotient overflows five bits");
`endif

endmodule

// ===== rtl/rgb565_gradient_color_unit.sv =====
// rgb565_gradient_color_unit: vertical gradient with fade-in, apb registers, 15-stage pipeline
// depends on rgc_pkg and rgc_blend
//
//  channel  | ports                                   | transfer when
//  ---------+-----------------------------------------+----------------------------------
//  input    | in_valid in_ready in_line in_elapsed    | in_valid & in_ready
//  result   | out_valid out_ready out_color           | out_valid & out_ready
//  config   | psel penable pwrite paddr pwdata prdata | psel & penable & pwrite (pready=1)
//
// one transfer per cycle in while in_ready is high, one per cycle out while
// out_ready is high; from input to out_valid: 4 stages for the line scaling,
// 5 in each of the two blends (multiply, sum, three divide stages) and the output register
// reset is synchronous; no clearing pass
// a result that arrives while out_color is held goes to a one-entry skid
// register, and only a full skid register freezes the pipeline and drops in_ready
module rgb565_gradient_color_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgc_pkg::IN_LINE_W-1:0]     in_line,
  input  logic [rgc_pkg::DUR_W-1:0]         in_elapsed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rgc_pkg::COLOR_W-1:0]       out_color,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int LW   = rgc_pkg::LINE_W;
  localparam int DW   = rgc_pkg::DUR_W;
  localparam int CW   = rgc_pkg::COLOR_W;
  localparam int ILW  = rgc_pkg::IN_LINE_W;
  localparam int PW   = LW + DW;
  localparam int K    = rgc_pkg::MIX_K;
  localparam int MW   = rgc_pkg::MIX_M_W;
  localparam int LAT  = rgc_pkg::BLEND_LAT;
  localparam int CMPW = ILW + 1;

  // configuration registers
  logic [DW-1:0] duration_r;
  logic [CW-1:0] top_color_r;
  logic [CW-1:0] bottom_color_r;
  logic [CW-1:0] start_color_r;
  logic          cfg_wr;
  rgc_pkg::rgc_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = rgc_pkg::rgc_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r     <= rgc_pkg::DURATION_RST;
      top_color_r    <= rgc_pkg::TOP_RST;
      bottom_color_r <= rgc_pkg::BOTTOM_RST;
      start_color_r  <= rgc_pkg::START_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rgc_pkg::REG_DURATION: duration_r     <= pwdata[DW-1:0];
        rgc_pkg::REG_TOP:      top_color_r    <= pwdata[CW-1:0];
        rgc_pkg::REG_BOTTOM:   bottom_color_r <= pwdata[CW-1:0];
        rgc_pkg::REG_START:    start_color_r  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rgc_pkg::REG_DURATION: prdata = 32'(duration_r);
      rgc_pkg::REG_TOP:      prdata = 32'(top_color_r);
      rgc_pkg::REG_BOTTOM:   prdata = 32'(bottom_color_r);
      rgc_pkg::REG_START:    prdata = 32'(start_color_r);
      default:               prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic in_xfer;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  logic skid_valid_r;
  logic out_valid_r;
  logic [CW-1:0] skid_color_r;
  logic [CW-1:0] out_color_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_xfer;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // stage 1: clamp line and elapsed
  logic [LW-1:0] line_nxt;
  logic [DW-1:0] el_nxt;
  logic [LW-1:0] s1_line_r;
  logic [DW-1:0] s1_el_r;

  always_comb begin
    if (CMPW'(in_line) >= CMPW'(rgc_pkg::LINES)) begin
      line_nxt = LW'(rgc_pkg::MIX_D);
    end else begin
      line_nxt = in_line[LW-1:0];
    end
    el_nxt = (in_elapsed > duration_r) ? duration_r : in_elapsed;
  end

  // stage 2: line * duration; stage 3: reciprocal estimate; stage 4: correction
  logic [PW-1:0]    s2_prod_r;
  logic [DW-1:0]    s2_el_r;
  logic [PW+MW-1:0] recip_prod;
  logic [PW-1:0]    s3_prod_r;
  logic [DW-1:0]    s3_q_r;
  logic [DW-1:0]    s3_el_r;
  logic [PW-1:0]    mix_rem;
  logic [DW-1:0]    mix_nxt;
  logic [DW-1:0]    s4_mix_r;
  logic [DW-1:0]    s4_el_r;

  assign recip_prod = (PW+MW)'(s2_prod_r) * (PW+MW)'(rgc_pkg::MIX_M);

  always_comb begin
    mix_rem = s3_prod_r - PW'(s3_q_r) * PW'(rgc_pkg::MIX_D);
    mix_nxt = s3_q_r;
    if (mix_rem >= PW'(rgc_pkg::MIX_D)) begin
      mix_nxt = s3_q_r + DW'(1);
    end
  end

  logic [DW-1:0] el_dly_r [0:LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_line_r <= line_nxt;
      s1_el_r   <= el_nxt;
      s2_prod_r <= PW'(s1_line_r) * PW'(duration_r);
      s2_el_r   <= s1_el_r;
      s3_prod_r <= s2_prod_r;
      s3_q_r    <= recip_prod[K+DW-1:K];
      s3_el_r   <= s2_el_r;
      s4_mix_r  <= mix_nxt;
      s4_el_r   <= s3_el_r;
      el_dly_r[0] <= s4_el_r;
      for (int i = 1; i < LAT; i++) begin
        el_dly_r[i] <= el_dly_r[i-1];
      end
    end
  end

  // two blends: vertical target, then fade from start color
  rgc_pkg::rgc_blend_req_t b1_req;
  rgc_pkg::rgc_blend_req_t b2_req;
  logic          b1_valid, b2_valid;
  logic [CW-1:0] b1_color, b2_color;

  always_comb begin
    b1_req.from_color = top_color_r;
    b1_req.to_color   = bottom_color_r;
    b1_req.step       = s4_mix_r;
    b2_req.from_color = start_color_r;
    b2_req.to_color   = b1_color;
    b2_req.step       = el_dly_r[LAT-1];
  end

  rgc_blend u_blend_vert (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_req    (b1_req),
    .den       (duration_r),
    .out_valid (b1_valid),
    .out_color (b1_color)
  );

  rgc_blend u_blend_fade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b1_valid),
    .in_req    (b2_req),
    .den       (duration_r),
    .out_valid (b2_valid),
    .out_color (b2_color)
  );

  // output register with skid entry
  logic [CW-1:0] final_color;
  logic          out_load;
  logic          skid_load;

  assign final_color = (duration_r == '0) ? start_color_r : b2_color;
  assign out_load    = skid_valid_r ? out_ready
                                    : (en && b2_valid && (!out_valid_r || out_ready));
  assign skid_load   = !skid_valid_r && en && b2_valid && out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_ready) begin
          skid_valid_r <= 1'b0;
        end
      end else if (en && b2_valid) begin
        if (out_valid_r && !out_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_color_r <= skid_valid_r ? skid_color_r : final_color;
    end
    if (skid_load) begin
      skid_color_r <= final_color;
    end
  end

  assign out_valid = out_valid_r;
  assign out_color = out_color_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid entry filled while output was free");

  a_zero_duration: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && duration_r == '0) |-> out_color_r == start_color_r)
    else $error("zero duration must give the start color");
`endif

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for rgb565_gradient_color_unit, directed table then random phases
// depends on rgc_pkg and the unit's rtl; registers are set over the apb port between phases
`timescale 1ns / 100ps

module tb;
  import rgc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 154;
  localparam int REPORT_MAX  = 10;
  localparam int DIR_ROWS    = 31;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

  // for items word is the elapsed time, for register rows the value written
  typedef struct packed {
    row_kind_t        kind;
    rgc_reg_t         reg_sel;
    logic [15:0]      word;
    logic [9:0]       line;
    logic             known;
    logic [15:0]      color;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [IN_LINE_W-1:0] in_line;
  logic [DUR_W-1:0] in_elapsed;
  logic out_valid;
  logic out_ready;
  logic [COLOR_W-1:0] out_color;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [15:0] cur_duration = DURATION_RST;
  logic [15:0] cur_top      = TOP_RST;
  logic [15:0] cur_bottom   = BOTTOM_RST;
  logic [15:0] cur_start    = START_RST;

  logic [15:0] expected_colors[$];
  logic [15:0] want;
  idle_mode_t  tx_mode = IDLE_NONE;
  idle_mode_t  rx_mode = IDLE_NONE;
  int rx_wait = 0;
  int errors = 0;
  int items_sent = 0;
  int colors_seen = 0;
  int cfg_writes = 0;
  int cycles = 0;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{ROW_ITEM, REG_DURATION, 16'd0,     10'd0,    1'b1, 16'hFFFF},
    '{ROW_ITEM, REG_DURATION, 16'd0,     10'd1023, 1'b1, 16'hFFFF},
    '{ROW_ITEM, REG_DURATION, 16'd65535, 10'd0,    1'b1, 16'h39E7},
    '{ROW_ITEM, REG_DURATION, 16'd4000,  10'd127,  1'b1, 16'h0842},
    '{ROW_ITEM, REG_DURATION, 16'd4000,  10'd128,  1'b1, 16'h0842},
    '{ROW_ITEM, REG_DURATION, 16'd65535, 10'd1023, 1'b1, 16'h0842},
    '{ROW_ITEM, REG_DURATION, 16'h5555,  10'h2AA,  1'b1, 16'h0842},
    '{ROW_ITEM, REG_DURATION, 16'hAAAA,  10'h155,  1'b1, 16'h0842},
    '{ROW_ITEM, REG_DURATION, 16'd4001,  10'd0,    1'b1, 16'h39E7},
    '{ROW_ITEM, REG_DURATION, 16'd2000,  10'd64,   1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd3999,  10'd126,  1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd1,     10'd1,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_DURATION, 16'd1,     10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_TOP,      16'h0000,  10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_BOTTOM,   16'hFFFF,  10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_START,    16'hF800,  10'd0,    1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd0,     10'd0,    1'b1, 16'hF800},
    '{ROW_ITEM, REG_DURATION, 16'd1,     10'd0,    1'b1, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd1,     10'd127,  1'b1, 16'hFFFF},
    '{ROW_ITEM, REG_DURATION, 16'd1,     10'd126,  1'b1, 16'h0000},
    '{ROW_CFG,  REG_DURATION, 16'd0,     10'd0,    1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd1234,  10'd64,   1'b1, 16'hF800},
    '{ROW_ITEM, REG_DURATION, 16'd65535, 10'd1023, 1'b1, 16'hF800},
    '{ROW_CFG,  REG_DURATION, 16'hFFFF,  10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_TOP,      16'hFFFF,  10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_BOTTOM,   16'h0000,  10'd0,    1'b0, 16'h0000},
    '{ROW_CFG,  REG_START,    16'h0000,  10'd0,    1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd32768, 10'd63,   1'b0, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd65535, 10'd127,  1'b1, 16'h0000},
    '{ROW_ITEM, REG_DURATION, 16'd65535, 10'd0,    1'b1, 16'hFFFF},
    '{ROW_ITEM, REG_DURATION, 16'd12345, 10'd100,  1'b0, 16'h0000}
  };

  rgb565_gradient_color_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_line    (in_line),
    .in_elapsed (in_elapsed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_color  (out_color),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] lane_mix(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] s, logic [31:0] den);
    return (a * (den - s) + b * s) / den;
  endfunction

  function automatic logic [15:0] blend_rgb565(logic [15:0] from_c, logic [15:0] to_c,
                                               logic [31:0] step, logic [31:0] den);
    logic [31:0] s, r, g, b;
    if (den == 0) return from_c;
    s = (step > den) ? den : step;
    r = lane_mix(32'(from_c[15:11]), 32'(to_c[15:11]), s, den);
    g = lane_mix(32'(from_c[10:5]), 32'(to_c[10:5]), s, den);
    b = lane_mix(32'(from_c[4:0]), 32'(to_c[4:0]), s, den);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic logic [15:0] gradient_color(logic [9:0] line, logic [15:0] elapsed);
    logic [31:0] ln, mix;
    logic [15:0] target;
    ln = (32'(line) >= LINES) ? 32'(LINES - 1) : 32'(line);
    mix = (ln * 32'(cur_duration)) / 32'(LINES - 1);
    target = blend_rgb565(cur_top, cur_bottom, mix, 32'(cur_duration));
    return blend_rgb565(cur_start, target, 32'(elapsed), 32'(cur_duration));
  endfunction

  function automatic int draw_wait(idle_mode_t m);
    case (m)
      IDLE_FULL:  return $urandom_range(0, 19);
      IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      default:    return 0;
    endcase
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_error(string what, logic [15:0] exp_v, logic [15:0] act_v);
    errors++;
    if (errors <= REPORT_MAX)
      $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  task automatic wait_drained();
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(rgc_reg_t r, logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {16'h0000, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (r)
      REG_DURATION: cur_duration = v;
      REG_TOP:      cur_top = v;
      REG_BOTTOM:   cur_bottom = v;
      REG_START:    cur_start = v;
      default: ;
    endcase
    cfg_writes++;
    // read back the same register
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== v) flag_error("register read", v, prdata[15:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [9:0] line, logic [15:0] elapsed,
                           logic known, logic [15:0] color);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_line <= line;
    in_elapsed <= elapsed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_colors.push_back(known ? color : gradient_color(line, elapsed));
    items_sent++;
  endtask

  task automatic run_phase(int p);
    logic [15:0] dur;
    logic [9:0] line;
    logic [15:0] elapsed;
    in_valid <= 1'b0;
    wait_drained();
    case (p)
      0:       dur = 16'd1;
      1:       dur = 16'hFFFF;
      2:       dur = 16'(LINES - 1);
      3:       dur = 16'($urandom_range(1, 300));
      default: dur = 16'($urandom_range(1, 65535));
    endcase
    cfg_write(REG_DURATION, dur);
    cfg_write(REG_TOP, pick_color());
    cfg_write(REG_BOTTOM, pick_color());
    cfg_write(REG_START, pick_color());
    tx_mode = idle_mode_t'(p % 3);
    rx_mode = idle_mode_t'((p + 1) % 3);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      line = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, LINES - 1));
      elapsed = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, dur));
      send_item(line, elapsed, 1'b0, 16'h0000);
    end
  endtask

  // result side: random stalls on out_ready, compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        colors_seen++;
        if (expected_colors.size() == 0) begin
          flag_error("unexpected transfer", 16'h0000, out_color);
        end else begin
          want = expected_colors.pop_front();
          if (out_color !== want) flag_error("color", want, out_color);
        end
        rx_wait = draw_wait(rx_mode);
      end
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors pending", cycles, expected_colors.size());
      $display("** rgb565_gradient_color_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_line <= '0;
    in_elapsed <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_FULL;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        wait_drained();
        cfg_write(dir_rows[i].reg_sel, dir_rows[i].word);
      end else begin
        send_item(dir_rows[i].line, dir_rows[i].word, dir_rows[i].known, dir_rows[i].color);
      end
    end
    for (int p = 0; p < PHASES; p++) run_phase(p);
    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    $display("%0d lines/times sent through %0d register writes, %0d colors compared, %0d errors",
             items_sent, cfg_writes, colors_seen, errors);
    if (errors == 0) begin
      $display("** rgb565_gradient_color_unit: PASSED **");
    end else begin
      $display("** rgb565_gradient_color_unit: FAILED **");
    end
    $finish;
  end

endmodule
